FILE: src/bii_pkg.sv
// bii_pkg: shared types and constants of the bilinear image interpolator
// no dependencies; used by every module of the block except bii_ram
package bii_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 8;
    localparam int COORD_BITS     = 15;
    localparam int INT_BITS       = COORD_BITS - FRAC_BITS;
    localparam int ROW_BITS       = 7;
    localparam int COL_BITS       = 7;
    localparam int MAX_WIDTH      = 128;
    localparam int MAX_HEIGHT     = 128;
    localparam int DIM_BITS       = 8;
    localparam int BANK_ROW_BITS  = ROW_BITS - 1;
    localparam int BANK_COL_BITS  = COL_BITS - 1;
    localparam int BANK_ADDR_BITS = BANK_ROW_BITS + BANK_COL_BITS;
    localparam int BANK_DEPTH     = (MAX_WIDTH * MAX_HEIGHT) / 4;
    localparam int NUM_BANKS      = 4;
    localparam int SCALE          = 1 << FRAC_BITS;
    localparam int WEIGHT_BITS    = FRAC_BITS + 1;
    localparam int ROW_SUM_BITS   = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int BLEND_BITS     = SAMPLE_BITS + 2 * FRAC_BITS + 2;

    localparam logic [DIM_BITS-1:0] DIM_MIN   = DIM_BITS'(2);
    localparam logic [DIM_BITS-1:0] WIDTH_MAX = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] HEIGHT_MAX = DIM_BITS'(MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(128);

    localparam logic [BLEND_BITS-1:0] ROUND_HALF = BLEND_BITS'(1) << (2 * FRAC_BITS - 1);

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic [ROW_BITS-1:0]           pixel_row;
        logic [COL_BITS-1:0]           pixel_col;
        logic signed [SAMPLE_BITS-1:0] pixel_value;
        logic [COORD_BITS-1:0]         query_x;
        logic [COORD_BITS-1:0]         query_y;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] interp_value;
        logic                          at_edge;
    } t_out_res;

    // blend controls that ride along with the memory read
    typedef struct packed {
        logic                 edge_hit;
        logic                 ypar;
        logic                 xpar;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } t_blend_ctl;

    // decoded request after the address stage
    typedef struct packed {
        logic                                          is_query;
        logic [1:0]                                    wr_bank;
        logic [BANK_ADDR_BITS-1:0]                     wr_addr;
        logic [SAMPLE_BITS-1:0]                        wr_data;
        logic [NUM_BANKS-1:0][BANK_ADDR_BITS-1:0]      rd_addr;
        t_blend_ctl                                    ctl;
    } t_s1;

    // per-stage advance enables of the blend pipeline
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

endpackage

FILE: src/bii_ram.sv
// bii_ram: generic single-write, single-read memory with registered read data
// no dependencies
module bii_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bii_addr.sv
// bii_addr: first stage, border test, clamping and bank address generation
// depends on bii_pkg
module bii_addr (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  bii_pkg::t_in_req             i_req,
    input  logic [bii_pkg::DIM_BITS-1:0] i_width,
    input  logic [bii_pkg::DIM_BITS-1:0] i_height,
    output bii_pkg::t_s1                 o_s1
);

    logic [bii_pkg::DIM_BITS-1:0]  w_eff, h_eff, wm1, hm1;
    logic [bii_pkg::INT_BITS-1:0]  xi, yi, xc, yc;
    logic [bii_pkg::DIM_BITS-1:0]  xi_ext, yi_ext, xc1, yc1, row_sel, col_sel;
    logic                          edge_hit;
    bii_pkg::t_s1                  n_s1;
    bii_pkg::t_s1                  r_s1;

    always_comb begin
        // out-of-range dimensions act as the nearest legal value
        w_eff = (i_width < bii_pkg::DIM_MIN) ? bii_pkg::DIM_MIN :
                (i_width > bii_pkg::WIDTH_MAX) ? bii_pkg::WIDTH_MAX : i_width;
        h_eff = (i_height < bii_pkg::DIM_MIN) ? bii_pkg::DIM_MIN :
                (i_height > bii_pkg::HEIGHT_MAX) ? bii_pkg::HEIGHT_MAX : i_height;
        wm1 = w_eff - bii_pkg::DIM_BITS'(1);
        hm1 = h_eff - bii_pkg::DIM_BITS'(1);

        xi = i_req.query_x[bii_pkg::COORD_BITS-1:bii_pkg::FRAC_BITS];
        yi = i_req.query_y[bii_pkg::COORD_BITS-1:bii_pkg::FRAC_BITS];
        xi_ext = bii_pkg::DIM_BITS'(xi);
        yi_ext = bii_pkg::DIM_BITS'(yi);

        edge_hit = (xi == '0) || (xi_ext >= wm1) || (yi == '0) || (yi_ext >= hm1);
        xc = (xi_ext > wm1) ? wm1[bii_pkg::INT_BITS-1:0] : xi;
        yc = (yi_ext > hm1) ? hm1[bii_pkg::INT_BITS-1:0] : yi;
        xc1 = bii_pkg::DIM_BITS'(xc) + bii_pkg::DIM_BITS'(1);
        yc1 = bii_pkg::DIM_BITS'(yc) + bii_pkg::DIM_BITS'(1);

        n_s1.is_query = (i_req.req_type == bii_pkg::REQ_QUERY);
        n_s1.wr_bank  = {i_req.pixel_row[0], i_req.pixel_col[0]};
        n_s1.wr_addr  = {i_req.pixel_row[bii_pkg::ROW_BITS-1:1],
                         i_req.pixel_col[bii_pkg::COL_BITS-1:1]};
        n_s1.wr_data  = i_req.pixel_value;

        // each bank holds one parity class of rows and columns; pick the
        // neighbor row and column whose parity matches the bank
        for (int b = 0; b < bii_pkg::NUM_BANKS; b++) begin
            row_sel = (b[1] == yc[0]) ? bii_pkg::DIM_BITS'(yc) : yc1;
            col_sel = (b[0] == xc[0]) ? bii_pkg::DIM_BITS'(xc) : xc1;
            n_s1.rd_addr[b] = {row_sel[bii_pkg::ROW_BITS-1:1], col_sel[bii_pkg::COL_BITS-1:1]};
        end

        n_s1.ctl.edge_hit = edge_hit;
        n_s1.ctl.ypar     = yc[0];
        n_s1.ctl.xpar     = xc[0];
        n_s1.ctl.fx       = i_req.query_x[bii_pkg::FRAC_BITS-1:0];
        n_s1.ctl.fy       = i_req.query_y[bii_pkg::FRAC_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

FILE: src/bii_blend.sv
// bii_blend: neighbor selection, x blend, y blend and rounding stages
// depends on bii_pkg
module bii_blend (
    input  logic                                                 i_clk,
    input  bii_pkg::t_pipe_en                                    i_en,
    input  bii_pkg::t_blend_ctl                                  i_ctl,
    input  logic [bii_pkg::NUM_BANKS-1:0][bii_pkg::SAMPLE_BITS-1:0] i_pix,
    output bii_pkg::t_out_res                                    o_res
);

    bii_pkg::t_blend_ctl r_ctl2;

    logic signed [bii_pkg::SAMPLE_BITS-1:0]  p00, p01, p10, p11;
    logic signed [bii_pkg::WEIGHT_BITS:0]    wx0, wx1, wy0, wy1;
    logic signed [bii_pkg::ROW_SUM_BITS-1:0] n_r0, n_r1, r_r0, r_r1;
    logic signed [bii_pkg::SAMPLE_BITS-1:0]  r_pix3, r_pix4;
    logic                                    r_edge3, r_edge4;
    logic [bii_pkg::FRAC_BITS-1:0]           r_fy3;
    logic signed [bii_pkg::BLEND_BITS-1:0]   n_v, r_v, rounded;
    bii_pkg::t_out_res                       n_res, r_res;

    // stage 2 control, aligned with the registered memory read
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_ctl2 <= i_ctl;
        end
    end

    // stage 3: blend along x
    always_comb begin
        p00 = i_pix[{r_ctl2.ypar, r_ctl2.xpar}];
        p01 = i_pix[{r_ctl2.ypar, ~r_ctl2.xpar}];
        p10 = i_pix[{~r_ctl2.ypar, r_ctl2.xpar}];
        p11 = i_pix[{~r_ctl2.ypar, ~r_ctl2.xpar}];
        wx1 = $signed({2'b00, r_ctl2.fx});
        wx0 = $signed((bii_pkg::WEIGHT_BITS + 1)'(bii_pkg::SCALE)) - wx1;
        n_r0 = wx0 * p00 + wx1 * p01;
        n_r1 = wx0 * p10 + wx1 * p11;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_r0    <= n_r0;
            r_r1    <= n_r1;
            r_pix3  <= p00;
            r_edge3 <= r_ctl2.edge_hit;
            r_fy3   <= r_ctl2.fy;
        end
    end

    // stage 4: blend along y
    always_comb begin
        wy1 = $signed({2'b00, r_fy3});
        wy0 = $signed((bii_pkg::WEIGHT_BITS + 1)'(bii_pkg::SCALE)) - wy1;
        n_v = wy0 * r_r0 + wy1 * r_r1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_v     <= n_v;
            r_pix4  <= r_pix3;
            r_edge4 <= r_edge3;
        end
    end

    // stage 5: round to nearest, ties upward, or pass the border pixel
    always_comb begin
        rounded = (r_v + $signed(bii_pkg::ROUND_HALF)) >>> (2 * bii_pkg::FRAC_BITS);
        n_res.interp_value = r_edge4 ? r_pix4 : rounded[bii_pkg::SAMPLE_BITS-1:0];
        n_res.at_edge      = r_edge4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: src/bilinear_image_interpolator.sv
// bilinear_image_interpolator: top level, request pipeline, pixel banks, config
// depends on bii_pkg, bii_ram, bii_addr, bii_blend
// a query result is registered in the address, memory read, x blend, y blend and output stages
// throughput: one request per cycle unless the result side stalls; the four
// pixel banks give every query its 2x2 neighborhood with one read per bank
// reset: synchronous active-low, clears valid bits and sets width and height to 128;
// pixel memory is not cleared and needs no clearing pass
module bilinear_image_interpolator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bii_pkg::t_in_req                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output bii_pkg::t_out_res                o_out_data,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [bii_pkg::DIM_BITS-1:0]     i_cfg_data
);

    // configuration registers
    logic [bii_pkg::DIM_BITS-1:0] r_width, r_height;

    // stage valid bits: s1 address stage, s2 memory read, s3 x blend,
    // s4 y blend, then the output register
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic en_s1;
    bii_pkg::t_pipe_en en;

    bii_pkg::t_s1 s1;

    logic [bii_pkg::NUM_BANKS-1:0]                             w_we;
    logic [bii_pkg::NUM_BANKS-1:0][bii_pkg::SAMPLE_BITS-1:0]   w_rdata;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bii_pkg::DIM_RESET;
            r_height <= bii_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bii_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                bii_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default:             r_width  <= r_width;
            endcase
        end
    end

    // a stage advances when it is empty or the next one advances, so
    // bubbles close up and a waiting result does not block new requests
    always_comb begin
        en.s5 = !r_out_valid || i_out_ready;
        en.s4 = !r_v4 || en.s5;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en_s1 = !r_v1 || en.s2;
    end

    assign o_in_ready = en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_v1 <= i_in_valid;
            end
            // pixel writes finish in the memory and go no further
            if (en.s2) begin
                r_v2 <= r_v1 && s1.is_query;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
            if (en.s4) begin
                r_v4 <= r_v3;
            end
            if (en.s5) begin
                r_out_valid <= r_v4;
            end
        end
    end

    bii_addr u_addr (
        .i_clk    (i_clk),
        .i_en     (en_s1),
        .i_req    (i_in_data),
        .i_width  (r_width),
        .i_height (r_height),
        .o_s1     (s1)
    );

    // pixel write and query read leave s1 in request order, so a query
    // always sees every write that came before it
    genvar b;
    generate
        for (b = 0; b < bii_pkg::NUM_BANKS; b++) begin : g_bank
            assign w_we[b] = r_v1 && !s1.is_query && en.s2 && (s1.wr_bank == 2'(b));

            bii_ram #(
                .WIDTH (bii_pkg::SAMPLE_BITS),
                .DEPTH (bii_pkg::BANK_DEPTH)
            ) u_bank (
                .i_clk   (i_clk),
                .i_we    (w_we[b]),
                .i_waddr (s1.wr_addr),
                .i_wdata (s1.wr_data),
                .i_re    (en.s2),
                .i_raddr (s1.rd_addr[b]),
                .o_rdata (w_rdata[b])
            );
        end
    endgenerate

    bii_blend u_blend (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ctl (s1.ctl),
        .i_pix (w_rdata),
        .o_res (o_out_data)
    );

    assign o_out_valid = r_out_valid;

    // at most one bank takes a pixel in a cycle
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_we))
        else $error("more than one bank written at once");

    // a pixel write leaves a bubble behind it in the read stage
    a_write_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we != '0) |=> !r_v2)
        else $error("pixel write passed into the read stage");

    // a full pipeline with a stalled result takes no new request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while pipeline full");

    // a finished blend reaches the output register when it advances
    a_blend_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en.s5) |=> r_out_valid)
        else $error("result lost between y blend and output");

endmodule

FILE: test/bilinear_image_interpolator_test.sv
// bilinear_image_interpolator_test: self-checking bench for the bilinear image interpolator
// predicts every query from its own pixel image and register copy, checks results in order
// depends on bii_pkg and bilinear_image_interpolator
`timescale 1ns / 100ps

module bilinear_image_interpolator_test;

    localparam int DRAIN_CYCLES = 12;      // pipeline latency plus margin
    localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int IDLE_PCT     = 14;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    bii_pkg::t_in_req             in_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    bii_pkg::t_out_res            out_data;
    logic                         cfg_we = 1'b0;
    logic                         cfg_idx = bii_pkg::CFG_WIDTH;
    logic [bii_pkg::DIM_BITS-1:0] cfg_data = '0;

    // own copy of the image and of the dimension registers
    logic signed [bii_pkg::SAMPLE_BITS-1:0] pixel_mem [bii_pkg::MAX_HEIGHT][bii_pkg::MAX_WIDTH];
    bit                                     pixel_known [bii_pkg::MAX_HEIGHT][bii_pkg::MAX_WIDTH];
    logic [bii_pkg::DIM_BITS-1:0]           width_reg = bii_pkg::DIM_RESET;
    logic [bii_pkg::DIM_BITS-1:0]           height_reg = bii_pkg::DIM_RESET;

    bii_pkg::t_out_res pending_results [$];
    int                failures = 0;
    int                cycle_count = 0;
    bit                no_gaps = 1'b0;      // set for the back-to-back stretch
    int                last_row = 0;
    int                last_col = 0;

    bilinear_image_interpolator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // run guard: a hang anywhere ends the run as a failure
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bilinear_image_interpolator_test failed");
            $finish;
        end
    end

    // result side backpressure, lifted during the back-to-back stretch
    always @(negedge clk) begin
        out_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // register values below 2 act as 2, values above the store size act as the store size
    function automatic int eff_dim(logic [bii_pkg::DIM_BITS-1:0] v, int limit);
        if (v < bii_pkg::DIM_MIN)
            return bii_pkg::DIM_MIN;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // top-left pixel of the neighborhood, or the clamped pixel of a border query
    function automatic void query_site(input logic [bii_pkg::COORD_BITS-1:0] qx, qy,
                                       output int row, col, output bit on_edge);
        int w;
        int h;
        w = eff_dim(width_reg, bii_pkg::MAX_WIDTH);
        h = eff_dim(height_reg, bii_pkg::MAX_HEIGHT);
        col = qx >> bii_pkg::FRAC_BITS;
        row = qy >> bii_pkg::FRAC_BITS;
        on_edge = (col == 0) || (col >= w - 1) || (row == 0) || (row >= h - 1);
        if (on_edge) begin
            if (col > w - 1)
                col = w - 1;
            if (row > h - 1)
                row = h - 1;
        end
    endfunction

    // blend along x then y with exact weights, single round to nearest (ties upward)
    function automatic bii_pkg::t_out_res blend_predict(logic [bii_pkg::COORD_BITS-1:0] qx, qy);
        int                row;
        int                col;
        bit                on_edge;
        longint            fx;
        longint            fy;
        longint            top;
        longint            bot;
        longint            acc;
        bii_pkg::t_out_res res;
        query_site(qx, qy, row, col, on_edge);
        fx = qx & (bii_pkg::SCALE - 1);
        fy = qy & (bii_pkg::SCALE - 1);
        if (on_edge) begin
            res.interp_value = pixel_mem[row][col];
            res.at_edge      = 1'b1;
        end else begin
            top = (bii_pkg::SCALE - fx) * longint'(pixel_mem[row][col])
                + fx * longint'(pixel_mem[row][col+1]);
            bot = (bii_pkg::SCALE - fx) * longint'(pixel_mem[row+1][col])
                + fx * longint'(pixel_mem[row+1][col+1]);
            acc = (bii_pkg::SCALE - fy) * top + fy * bot;
            acc = (acc + (longint'(1) << (2 * bii_pkg::FRAC_BITS - 1)))
                  >>> (2 * bii_pkg::FRAC_BITS);
            res.interp_value = acc[bii_pkg::SAMPLE_BITS-1:0];
            res.at_edge      = 1'b0;
        end
        return res;
    endfunction

    // one request: optional idle cycles, hold until accepted, then update the image copy
    // entered and left at a falling edge
    task automatic send_req(bii_pkg::t_in_req r);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.req_type == bii_pkg::REQ_WRITE) begin
            pixel_mem[r.pixel_row][r.pixel_col]   = r.pixel_value;
            pixel_known[r.pixel_row][r.pixel_col] = 1'b1;
        end else begin
            pending_results.push_back(blend_predict(r.query_x, r.query_y));
        end
        @(negedge clk);
    endtask

    function automatic logic [bii_pkg::SAMPLE_BITS-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 16'h7fff;
        if (pick < 10)
            return 16'h8000;
        return bii_pkg::SAMPLE_BITS'($urandom);
    endfunction

    task automatic write_pixel(int row, int col, logic [bii_pkg::SAMPLE_BITS-1:0] value);
        bii_pkg::t_in_req r;
        r.req_type    = bii_pkg::REQ_WRITE;
        r.pixel_row   = bii_pkg::ROW_BITS'(row);
        r.pixel_col   = bii_pkg::COL_BITS'(col);
        r.pixel_value = value;
        r.query_x     = bii_pkg::COORD_BITS'($urandom);     // ignored on a write
        r.query_y     = bii_pkg::COORD_BITS'($urandom);
        send_req(r);
    endtask

    task automatic ensure_pixel(int row, int col);
        if (!pixel_known[row][col])
            write_pixel(row, col, random_sample());
    endtask

    // query after making sure every pixel it reads holds a written value
    task automatic query_point(int qx, int qy);
        int               row;
        int               col;
        bit               on_edge;
        bii_pkg::t_in_req r;
        query_site(bii_pkg::COORD_BITS'(qx), bii_pkg::COORD_BITS'(qy), row, col, on_edge);
        ensure_pixel(row, col);
        if (!on_edge) begin
            ensure_pixel(row, col + 1);
            ensure_pixel(row + 1, col);
            ensure_pixel(row + 1, col + 1);
        end
        last_row      = row;
        last_col      = col;
        r.req_type    = bii_pkg::REQ_QUERY;
        r.pixel_row   = bii_pkg::ROW_BITS'($urandom);       // ignored on a query
        r.pixel_col   = bii_pkg::COL_BITS'($urandom);
        r.pixel_value = bii_pkg::SAMPLE_BITS'($urandom);
        r.query_x     = bii_pkg::COORD_BITS'(qx);
        r.query_y     = bii_pkg::COORD_BITS'(qy);
        send_req(r);
    endtask

    // dimension change only with the pipeline empty
    task automatic set_dims(logic [bii_pkg::DIM_BITS-1:0] w, logic [bii_pkg::DIM_BITS-1:0] h);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= bii_pkg::CFG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_idx  <= bii_pkg::CFG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we   <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    // coordinate mix: mostly inside the image, plus border rows, far-out values
    // and interior points with extreme fractions
    function automatic int pick_coord(int dim);
        int pick;
        int ipart;
        pick = $urandom_range(99);
        if (pick < 55)
            return $urandom_range(dim * bii_pkg::SCALE - 1);
        if (pick < 70) begin
            ipart = $urandom_range(1) ? 0 : dim - 1;
            return ipart * bii_pkg::SCALE + $urandom_range(bii_pkg::SCALE - 1);
        end
        if (pick < 80)
            return $urandom_range(32767);
        ipart = (dim > 2) ? $urandom_range(dim - 2, 1) : 0;
        return ipart * bii_pkg::SCALE + ($urandom_range(1) ? bii_pkg::SCALE - 1 : 0);
    endfunction

    // default 128x128 after reset: far corner, origin, last interior cell
    task automatic test_reset_dims();
        write_pixel(bii_pkg::MAX_HEIGHT - 1, bii_pkg::MAX_WIDTH - 1, 16'h7fff);
        write_pixel(0, 0, 16'h8000);
        query_point(32'h7fff, 32'h7fff);
        query_point(0, 0);
        query_point(126 * bii_pkg::SCALE + 255, 126 * bii_pkg::SCALE + 255);
    endtask

    // every border condition on a 5x4 image, with clamping beyond it
    task automatic test_border();
        set_dims(8'd5, 8'd4);
        query_point(0 * bii_pkg::SCALE + 77, 2 * bii_pkg::SCALE + 3);     // left column
        query_point(4 * bii_pkg::SCALE + 255, 1 * bii_pkg::SCALE);        // right column
        query_point(9 * bii_pkg::SCALE + 1, 2 * bii_pkg::SCALE);          // beyond the right
        query_point(2 * bii_pkg::SCALE + 5, 0);                           // top row
        query_point(1 * bii_pkg::SCALE, 3 * bii_pkg::SCALE + 200);        // bottom row
        query_point(32'h7fff, 32'h7fff);                                  // beyond both sides
        query_point(3 * bii_pkg::SCALE + 128, 2 * bii_pkg::SCALE + 64);   // one interior point
    endtask

    // half-way ties both signs, then full-scale samples of opposite sign
    task automatic test_blend_rounding();
        write_pixel(1, 1, 16'd1);
        write_pixel(1, 2, 16'd0);
        write_pixel(2, 1, 16'd0);
        write_pixel(2, 2, 16'd0);
        query_point(1 * bii_pkg::SCALE + 128, 1 * bii_pkg::SCALE);
        write_pixel(1, 1, -16'sd1);
        query_point(1 * bii_pkg::SCALE + 128, 1 * bii_pkg::SCALE);
        write_pixel(1, 1, 16'h7fff);
        write_pixel(1, 2, 16'h8000);
        write_pixel(2, 1, 16'h8000);
        write_pixel(2, 2, 16'h7fff);
        query_point(1 * bii_pkg::SCALE, 1 * bii_pkg::SCALE);
        query_point(1 * bii_pkg::SCALE + 255, 1 * bii_pkg::SCALE + 255);
        query_point(1 * bii_pkg::SCALE + 128, 1 * bii_pkg::SCALE + 128);
    endtask

    // register values out of range act as the nearest legal size
    task automatic test_dim_clamp();
        set_dims(8'd0, 8'd1);
        query_point(1 * bii_pkg::SCALE + 10, 1 * bii_pkg::SCALE + 10);
        set_dims(8'd255, 8'd129);
        query_point(127 * bii_pkg::SCALE, 64 * bii_pkg::SCALE + 3);
        query_point(100 * bii_pkg::SCALE + 7, 120 * bii_pkg::SCALE + 250);
        set_dims(8'd1, 8'd255);
        query_point(0 * bii_pkg::SCALE + 128, 60 * bii_pkg::SCALE + 128);
    endtask

    // pixels written outside the active area are kept and read once it grows
    task automatic test_hidden_pixels();
        set_dims(8'd2, 8'd2);
        write_pixel(50, 60, -16'sd1234);
        write_pixel(51, 61, 16'sd4321);
        set_dims(8'd128, 8'd128);
        query_point(60 * bii_pkg::SCALE + 100, 50 * bii_pkg::SCALE + 30);
    endtask

    // mixed writes and queries; some writes land in the last neighborhood so
    // a query can follow closely on the pixels it reads
    task automatic test_random_traffic(logic [bii_pkg::DIM_BITS-1:0] w_set, h_set, int count);
        int w;
        int h;
        int pick;
        set_dims(w_set, h_set);
        w = eff_dim(w_set, bii_pkg::MAX_WIDTH);
        h = eff_dim(h_set, bii_pkg::MAX_HEIGHT);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 15)
                write_pixel($urandom_range(bii_pkg::MAX_HEIGHT - 1),
                            $urandom_range(bii_pkg::MAX_WIDTH - 1), random_sample());
            else if (pick < 30)
                write_pixel((last_row < bii_pkg::MAX_HEIGHT - 1) ?
                                last_row + $urandom_range(1) : last_row,
                            (last_col < bii_pkg::MAX_WIDTH - 1) ?
                                last_col + $urandom_range(1) : last_col,
                            random_sample());
            else
                query_point(pick_coord(w), pick_coord(h));
        end
    endtask

    // back-to-back requests with the result side always ready
    task automatic test_streaming();
        no_gaps = 1'b1;
        test_random_traffic(bii_pkg::DIM_BITS'($urandom_range(255)),
                            bii_pkg::DIM_BITS'($urandom_range(255)), 150);
        no_gaps = 1'b0;
    endtask

    // in-order result check against the oldest expectation
    always @(posedge clk) begin
        bii_pkg::t_out_res want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result interp_value %0d at_edge %0b",
                         $time, out_data.interp_value, out_data.at_edge);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.interp_value !== want.interp_value) begin
                    $display("%0t: interp_value expected %0d actual %0d",
                             $time, want.interp_value, out_data.interp_value);
                    failures++;
                end
                if (out_data.at_edge !== want.at_edge) begin
                    $display("%0t: at_edge expected %0b actual %0b",
                             $time, want.at_edge, out_data.at_edge);
                    failures++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_dims();
        test_border();
        test_blend_rounding();
        test_dim_clamp();
        test_hidden_pixels();

        test_random_traffic(8'd128, 8'd128, 100);
        test_random_traffic(8'd2, 8'd2, 100);
        test_random_traffic(8'd255, 8'd0, 100);
        test_random_traffic(8'd3, 8'd129, 110);
        test_random_traffic(8'd17, 8'd5, 100);
        test_random_traffic(bii_pkg::DIM_BITS'($urandom_range(255)),
                            bii_pkg::DIM_BITS'($urandom_range(255)), 100);
        test_streaming();

        // drain: nothing outstanding, then let any stray result show up
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("bilinear_image_interpolator_test passed");
        else
            $display("bilinear_image_interpolator_test failed");
        $finish;
    end

endmodule

FILE: files.f
src/bii_pkg.sv
src/bii_ram.sv
src/bii_addr.sv
src/bii_blend.sv
src/bilinear_image_interpolator.sv
test/bilinear_image_interpolator_test.sv
